// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion, disabled while reset is asserted (active low).
`define FSLLS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Shorthand on the block's own clock and reset.
`define FSLLS_ASSERT(lbl, prop, msg) \
  `FSLLS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/fslls_pkg.sv =====
// ----------------------------------------------------------------------------
// fslls_pkg
// Shared constants and types of the flow sequence/loss/latency statistics block.
// ----------------------------------------------------------------------------
package fslls_pkg;

  localparam int unsigned NODE_COUNT_DEF = 16;

  localparam logic [15:0] FLAG_DATA       = 16'hFFFF;
  localparam logic [15:0] FLAG_BACKGROUND = 16'hBBBB;

  typedef enum logic [1:0] {
    ST_FOREIGN  = 2'd0,
    ST_IN_ORDER = 2'd1,
    ST_GAP      = 2'd2,
    ST_LATE     = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic clear;   // write zeros at the sweep address
    logic load;    // capture the incoming request
    logic read;    // read both memories
    logic calc1;
    logic calc2;
    logic calc3;
    logic commit;  // write back and load result register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
  } ctrl_sts_t;

endpackage

// ===== hdl/flow_sequence_loss_latency_stats.sv =====
// ----------------------------------------------------------------------------
// flow_sequence_loss_latency_stats
// Per-flow sequence gap, loss counting and one-way delay statistics.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake                  Payload
// in       in   in_valid_i / in_ready_o    source_node_i .. packet_bytes_i
// out      out  out_valid_o / out_ready_i  status_o .. byte_total_o
// cfg      in   cfg_we_i                   cfg_wdata_i (delay offset)
//
// A request passes through read, three arithmetic steps and write-back, the
// single read-modify-write of the slot and flow memories, before the result
// is registered; the next request is taken only after that write-back. A
// result may wait in the output register while the next request is taken;
// a result still held stalls write-back of the next.
// After reset a clearing sweep zeroes every entry of both memories; in_ready_o
// stays low meanwhile.
// ----------------------------------------------------------------------------
module flow_sequence_loss_latency_stats #(
  parameter int unsigned NODE_COUNT = fslls_pkg::NODE_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  source_node_i,
  input  logic [3:0]  dest_node_i,
  input  logic [31:0] arrival_time_i,
  input  logic [15:0] header_flag_i,
  input  logic [31:0] sequence_number_i,
  input  logic [31:0] send_time_i,
  input  logic [15:0] packet_bytes_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        is_background_o,
  output logic [31:0] lost_total_o,
  output logic [31:0] one_way_delay_o,
  output logic [31:0] delay_min_o,
  output logic [31:0] delay_max_o,
  output logic [31:0] packet_total_o,
  output logic [31:0] byte_total_o
);

  fslls_pkg::ctrl_cmd_t cmd;
  fslls_pkg::ctrl_sts_t sts;

  fslls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fslls_dp #(
    .NODE_COUNT (NODE_COUNT)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .source_node_i     (source_node_i),
    .dest_node_i       (dest_node_i),
    .arrival_time_i    (arrival_time_i),
    .header_flag_i     (header_flag_i),
    .sequence_number_i (sequence_number_i),
    .send_time_i       (send_time_i),
    .packet_bytes_i    (packet_bytes_i),
    .status_o          (status_o),
    .is_background_o   (is_background_o),
    .lost_total_o      (lost_total_o),
    .one_way_delay_o   (one_way_delay_o),
    .delay_min_o       (delay_min_o),
    .delay_max_o       (delay_max_o),
    .packet_total_o    (packet_total_o),
    .byte_total_o      (byte_total_o)
  );

endmodule

// ===== hdl/fslls_ctrl.sv =====
// ----------------------------------------------------------------------------
// fslls_ctrl
// Sequencer: clearing sweep, request capture, read-modify-write steps, output
// handshake.
// ----------------------------------------------------------------------------
module fslls_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  fslls_pkg::ctrl_sts_t  sts_i,
  output fslls_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_CALC1 = 7'b0001000,
    S_CALC2 = 7'b0010000,
    S_CALC3 = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_CALC1;
      end
      S_CALC1: begin
        cmd_o.calc1 = 1'b1;
        state_d     = S_CALC2;
      end
      S_CALC2: begin
        cmd_o.calc2 = 1'b1;
        state_d     = S_CALC3;
      end
      S_CALC3: begin
        cmd_o.calc3 = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        // write-back waits until the result register is free
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/fslls_dp.sv =====
// ----------------------------------------------------------------------------
// fslls_dp
// Datapath: per-slot and per-flow statistics memories, sequence/loss and
// delay arithmetic, result register.
// ----------------------------------------------------------------------------
module fslls_dp #(
  parameter int unsigned NODE_COUNT = fslls_pkg::NODE_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fslls_pkg::ctrl_cmd_t  cmd_i,
  output fslls_pkg::ctrl_sts_t  sts_o,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i,
  input  logic [3:0]            source_node_i,
  input  logic [3:0]            dest_node_i,
  input  logic [31:0]           arrival_time_i,
  input  logic [15:0]           header_flag_i,
  input  logic [31:0]           sequence_number_i,
  input  logic [31:0]           send_time_i,
  input  logic [15:0]           packet_bytes_i,
  output logic [1:0]            status_o,
  output logic                  is_background_o,
  output logic [31:0]           lost_total_o,
  output logic [31:0]           one_way_delay_o,
  output logic [31:0]           delay_min_o,
  output logic [31:0]           delay_max_o,
  output logic [31:0]           packet_total_o,
  output logic [31:0]           byte_total_o
);

  localparam int unsigned NW         = $clog2(NODE_COUNT);
  localparam int unsigned FLOW_AW    = 2 * NW;
  localparam int unsigned SLOT_AW    = FLOW_AW + 1;
  localparam int unsigned SLOT_DEPTH = 2 ** SLOT_AW;
  localparam int unsigned FLOW_DEPTH = 2 ** FLOW_AW;

  typedef struct packed {
    logic [31:0] exp_seq;
    logic [31:0] loss;
    logic [31:0] pkts;
    logic [31:0] bytes;
  } slot_word_t;

  typedef struct packed {
    logic [31:0] acc;
    logic [31:0] dmin;
    logic [31:0] dmax;
  } flow_word_t;

  // -------------------------------------------------------------------------
  // configuration and clearing sweep
  logic [15:0]        offset_q;
  logic [SLOT_AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q  <= '0;
      clr_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        offset_q <= cfg_wdata_i;
      end
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  assign sts_o.clear_last = &clr_cnt_q;

  // -------------------------------------------------------------------------
  // request capture
  logic [NW+3:0] src_x, dst_x;
  logic          src_ok, dst_ok, is_data, is_bg, foreign_d;

  assign src_x   = {{NW{1'b0}}, source_node_i};
  assign dst_x   = {{NW{1'b0}}, dest_node_i};
  assign src_ok  = src_x < (NW + 4)'(NODE_COUNT);
  assign dst_ok  = dst_x < (NW + 4)'(NODE_COUNT);
  assign is_data = header_flag_i == fslls_pkg::FLAG_DATA;
  assign is_bg   = header_flag_i == fslls_pkg::FLAG_BACKGROUND;
  assign foreign_d = !(is_data || is_bg) || !src_ok || !dst_ok;

  logic [NW-1:0] src_q, dst_q;
  logic          bg_q, foreign_q;
  logic [31:0]   now_q, seq_q, sent_q;
  logic [15:0]   bytes_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      src_q     <= src_x[NW-1:0];
      dst_q     <= dst_x[NW-1:0];
      bg_q      <= is_bg;
      foreign_q <= foreign_d;
      now_q     <= arrival_time_i;
      seq_q     <= sequence_number_i;
      sent_q    <= send_time_i;
      bytes_q   <= packet_bytes_i;
    end
  end

  logic [FLOW_AW-1:0] flow_addr;
  logic [SLOT_AW-1:0] slot_addr;

  assign flow_addr = {src_q, dst_q};
  assign slot_addr = {bg_q, flow_addr};

  // -------------------------------------------------------------------------
  // memories
  slot_word_t slot_mem [SLOT_DEPTH];
  flow_word_t flow_mem [FLOW_DEPTH];
  slot_word_t slot_rd_q, slot_wdata;
  flow_word_t flow_rd_q, flow_wdata;
  logic [SLOT_AW-1:0] slot_waddr;
  logic [FLOW_AW-1:0] flow_waddr;
  logic               mem_we;

  assign mem_we = cmd_i.clear || (cmd_i.commit && !foreign_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
      flow_mem[flow_waddr] <= flow_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      slot_rd_q <= slot_mem[slot_addr];
      flow_rd_q <= flow_mem[flow_addr];
    end
  end

  // -------------------------------------------------------------------------
  // step 1: next sequence, counters, access delay
  logic [31:0] next_q, pkts_q, bytes_tot_q, acc_q;
  logic [32:0] age;

  assign age = {1'b0, now_q} - {1'b0, sent_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc1) begin
      next_q      <= slot_rd_q.exp_seq + 32'd1;
      pkts_q      <= slot_rd_q.pkts + 32'd1;
      bytes_tot_q <= slot_rd_q.bytes + {16'd0, bytes_q};
      // send time after arrival keeps the stored access delay
      acc_q       <= age[32] ? flow_rd_q.acc : age[31:0];
    end
  end

  // step 2: sequence classification, one-way delay
  fslls_pkg::status_e st_q;
  logic [31:0]        diff_q, owd_q;
  logic [32:0]        seq_diff, owd_sum;

  assign seq_diff = {1'b0, seq_q} - {1'b0, next_q};
  assign owd_sum  = {17'd0, offset_q} + {1'b0, acc_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc2) begin
      if (seq_diff == 33'd0) begin
        st_q <= fslls_pkg::ST_IN_ORDER;
      end else if (!seq_diff[32]) begin
        st_q <= fslls_pkg::ST_GAP;
      end else begin
        st_q <= fslls_pkg::ST_LATE;
      end
      diff_q <= seq_diff[31:0];
      owd_q  <= owd_sum[32] ? '1 : owd_sum[31:0];
    end
  end

  // step 3: loss update, min/max
  logic [31:0] loss_q, dmin_q, dmax_q, loss_d;
  logic [32:0] loss_sum;

  assign loss_sum = {1'b0, slot_rd_q.loss} + {1'b0, diff_q};

  always_comb begin
    case (st_q)
      fslls_pkg::ST_GAP:  loss_d = loss_sum[32] ? '1 : loss_sum[31:0];
      fslls_pkg::ST_LATE: loss_d = (slot_rd_q.loss == 32'd0) ? 32'd0
                                                              : slot_rd_q.loss - 32'd1;
      default:            loss_d = slot_rd_q.loss;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc3) begin
      loss_q <= loss_d;
      // zero max marks a flow not yet seen
      if (flow_rd_q.dmax == 32'd0) begin
        dmin_q <= owd_q;
        dmax_q <= owd_q;
      end else begin
        dmin_q <= (owd_q < flow_rd_q.dmin) ? owd_q : flow_rd_q.dmin;
        dmax_q <= (owd_q > flow_rd_q.dmax) ? owd_q : flow_rd_q.dmax;
      end
    end
  end

  // -------------------------------------------------------------------------
  // write-back
  logic [31:0] exp_new;

  always_comb begin
    case (st_q)
      fslls_pkg::ST_IN_ORDER: exp_new = next_q;
      fslls_pkg::ST_GAP:      exp_new = seq_q;
      default:                exp_new = slot_rd_q.exp_seq;
    endcase
  end

  always_comb begin
    if (cmd_i.clear) begin
      slot_waddr = clr_cnt_q;
      flow_waddr = clr_cnt_q[FLOW_AW-1:0];
      slot_wdata = '0;
      flow_wdata = '0;
    end else begin
      slot_waddr = slot_addr;
      flow_waddr = flow_addr;
      slot_wdata = '{exp_seq: exp_new, loss: loss_q, pkts: pkts_q, bytes: bytes_tot_q};
      flow_wdata = '{acc: acc_q, dmin: dmin_q, dmax: dmax_q};
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (foreign_q) begin
        status_o        <= fslls_pkg::ST_FOREIGN;
        is_background_o <= 1'b0;
        lost_total_o    <= '0;
        one_way_delay_o <= '0;
        delay_min_o     <= '0;
        delay_max_o     <= '0;
        packet_total_o  <= '0;
        byte_total_o    <= '0;
      end else begin
        status_o        <= st_q;
        is_background_o <= bg_q;
        lost_total_o    <= loss_q;
        one_way_delay_o <= owd_q;
        delay_min_o     <= dmin_q;
        delay_max_o     <= dmax_q;
        packet_total_o  <= pkts_q;
        byte_total_o    <= bytes_tot_q;
      end
    end
  end

endmodule

// ===== hdl/fslls_checker.sv =====
// ----------------------------------------------------------------------------
// fslls_checker
// Port-level checks of the statistics block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fslls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic        is_background_o,
  input logic [31:0] lost_total_o,
  input logic [31:0] one_way_delay_o,
  input logic [31:0] delay_min_o,
  input logic [31:0] delay_max_o,
  input logic [31:0] packet_total_o,
  input logic [31:0] byte_total_o
);

  // result valid, status, lost and byte totals held while stalled
  property p_out_hold;
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(status_o) && $stable(lost_total_o) && $stable(byte_total_o);
  endproperty

  // one request at a time
  property p_one_in_flight;
    in_valid_i && in_ready_o |=> !in_ready_o;
  endproperty

  // foreign requests report all zero
  property p_foreign_zero;
    out_valid_o && (status_o == fslls_pkg::ST_FOREIGN) |->
      !is_background_o && (lost_total_o == 32'd0) && (one_way_delay_o == 32'd0) &&
      (delay_min_o == 32'd0) && (delay_max_o == 32'd0) &&
      (packet_total_o == 32'd0) && (byte_total_o == 32'd0);
  endproperty

  // current delay lies within the flow's min/max
  property p_delay_bounds;
    out_valid_o |-> (delay_min_o <= one_way_delay_o) && (one_way_delay_o <= delay_max_o);
  endproperty

  `FSLLS_ASSERT(a_out_hold, p_out_hold, "result changed while stalled")
  `FSLLS_ASSERT(a_one_in_flight, p_one_in_flight, "request taken while busy")
  `FSLLS_ASSERT(a_foreign_zero, p_foreign_zero, "foreign result not zero")
  `FSLLS_ASSERT(a_delay_bounds, p_delay_bounds, "delay outside min/max")

endmodule

bind flow_sequence_loss_latency_stats fslls_checker u_fslls_checker (.*);
